/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Short forms for clocked properties that are disabled while reset is low.
// The module that uses them must have clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/bpl_pkg.sv */
// ----------------------------------------------------------------------------
// bpl_pkg
// Mode and status codes shared by the positional list core.
// ----------------------------------------------------------------------------
`default_nettype none

package bpl_pkg;

	typedef logic signed [31:0] word_t;
	typedef logic [2:0] mode_t;
	typedef logic [1:0] status_t;

	localparam mode_t MODE_INS_FRONT = 3'd0;
	localparam mode_t MODE_INS_BACK  = 3'd1;
	localparam mode_t MODE_INS_AT    = 3'd2;
	localparam mode_t MODE_DEL_FRONT = 3'd3;
	localparam mode_t MODE_DEL_BACK  = 3'd4;
	localparam mode_t MODE_DEL_AT    = 3'd5;
	localparam mode_t MODE_DUMP      = 3'd6;

	localparam status_t ST_OK     = 2'd0;
	localparam status_t ST_EMPTY  = 2'd1;
	localparam status_t ST_BADPOS = 2'd2;
	localparam status_t ST_FULL   = 2'd3;

endpackage

`default_nettype wire

/* hdl/bpl_ram.sv */
// ----------------------------------------------------------------------------
// bpl_ram
// Entry store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bpl_ram #(
	parameter int DEPTH = 16,
	parameter int AW = 4
) (
	input  wire               clk,
	input  wire               we,
	input  wire  [AW-1:0]     waddr,
	input  bpl_pkg::word_t    wdata,
	input  wire  [AW-1:0]     raddr,
	output bpl_pkg::word_t    rdata
);

	bpl_pkg::word_t mem [DEPTH];
	bpl_pkg::word_t rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, with registered read data.
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

/* hdl/bounded_positional_list_core.sv */
// ----------------------------------------------------------------------------
// bounded_positional_list_core
// Ordered list of up to DEPTH signed words kept in a single RAM, with
// positional insert and delete done by moving entries one at a time.
// ----------------------------------------------------------------------------
//  Channel | Handshake           | Payload
//  --------+---------------------+-------------------------------
//  input   | in_valid, in_stall  | mode, position, value
//  output  | out_valid, out_stall| status, entry, last, length
//
//  An insert or delete steps through a read state and a write state per moved entry,
//  since each moved entry costs a RAM read and a write on the single port pair.
//  A dump reads and hands out entries in turn; an error or empty case goes to emit.
//  Reset clears the state, count and out_valid; the entry store needs no clearing.
//  One item is worked on at a time; a stalled result holds the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_positional_list_core #(
	parameter int DEPTH = 16
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_stall,
	input  bpl_pkg::mode_t     mode,
	input  wire  [6:0]         position,
	input  bpl_pkg::word_t     value,
	output logic               out_valid,
	input  wire                out_stall,
	output bpl_pkg::status_t   status,
	output bpl_pkg::word_t     entry,
	output logic               last,
	output logic [6:0]         length
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int WW = 8;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_UP_RD = 3'd1;
	localparam logic [2:0] S_UP_WR = 3'd2;
	localparam logic [2:0] S_DN_RD = 3'd3;
	localparam logic [2:0] S_DN_WR = 3'd4;
	localparam logic [2:0] S_DP_RD = 3'd5;
	localparam logic [2:0] S_DP_WT = 3'd6;
	localparam logic [2:0] S_EMIT  = 3'd7;

	logic [2:0]        state_q;
	logic [CW-1:0]     cnt_q;
	logic [AW-1:0]     ptr_q;
	logic [AW-1:0]     idx_q;
	bpl_pkg::word_t    val_q;
	bpl_pkg::status_t  st_q;

	logic              ov_q;
	bpl_pkg::status_t  ost_q;
	bpl_pkg::word_t    oent_q;
	logic              olast_q;
	logic [6:0]        olen_q;

	logic              we;
	logic [AW-1:0]     waddr;
	bpl_pkg::word_t    wdata;
	logic [AW-1:0]     raddr;
	bpl_pkg::word_t    rdata;

	logic              accept;
	logic              out_free;
	logic [WW-1:0]     cnt_w;
	logic [WW-1:0]     pos_w;
	logic [WW-1:0]     ptr_w;
	logic              full;
	logic              dump_last;

	assign accept   = in_valid && (state_q == S_IDLE);
	assign in_stall = (state_q != S_IDLE);
	assign out_free = !ov_q || !out_stall;
	assign cnt_w    = WW'(cnt_q);
	assign pos_w    = WW'(position);
	assign ptr_w    = WW'(ptr_q);
	assign full     = (cnt_w >= WW'(DEPTH));
	assign dump_last = ((ptr_w + 8'd1) == cnt_w);

	bpl_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// RAM port control for the moving and dumping states.
	always_comb begin
		we    = 1'b0;
		waddr = ptr_q;
		wdata = rdata;
		raddr = ptr_q;
		case (state_q)
			S_UP_RD: begin
				raddr = ptr_q - AW'(1);
				if (ptr_q == idx_q) begin
					we    = 1'b1;
					wdata = val_q;
				end
			end
			S_UP_WR: we = 1'b1;
			S_DN_RD: raddr = ptr_q + AW'(1);
			S_DN_WR: we = 1'b1;
			default: ;
		endcase
	end

	// Sequencer: decode an item, move entries, emit results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			if (ov_q && !out_stall) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						st_q  <= bpl_pkg::ST_OK;
						val_q <= value;
						ptr_q <= AW'(cnt_q);
						state_q <= S_EMIT;
						case (mode)
							bpl_pkg::MODE_INS_FRONT, bpl_pkg::MODE_INS_BACK: begin
								if (full) begin
									st_q <= bpl_pkg::ST_FULL;
								end else begin
									idx_q   <= (mode == bpl_pkg::MODE_INS_FRONT) ?
										'0 : AW'(cnt_q);
									state_q <= S_UP_RD;
								end
							end
							bpl_pkg::MODE_INS_AT: begin
								if (pos_w == '0 || pos_w > cnt_w + 8'd1) begin
									st_q <= bpl_pkg::ST_BADPOS;
								end else if (full) begin
									st_q <= bpl_pkg::ST_FULL;
								end else begin
									idx_q   <= AW'(pos_w - 8'd1);
									state_q <= S_UP_RD;
								end
							end
							bpl_pkg::MODE_DEL_FRONT, bpl_pkg::MODE_DEL_BACK: begin
								if (cnt_q == '0) begin
									st_q <= bpl_pkg::ST_EMPTY;
								end else begin
									ptr_q   <= (mode == bpl_pkg::MODE_DEL_FRONT) ?
										'0 : AW'(cnt_w - 8'd1);
									state_q <= S_DN_RD;
								end
							end
							bpl_pkg::MODE_DEL_AT: begin
								if (cnt_q == '0) begin
									st_q <= bpl_pkg::ST_EMPTY;
								end else if (pos_w == '0 || pos_w > cnt_w) begin
									st_q <= bpl_pkg::ST_BADPOS;
								end else begin
									ptr_q   <= AW'(pos_w - 8'd1);
									state_q <= S_DN_RD;
								end
							end
							bpl_pkg::MODE_DUMP: begin
								if (cnt_q == '0) begin
									st_q <= bpl_pkg::ST_EMPTY;
								end else begin
									ptr_q   <= '0;
									state_q <= S_DP_RD;
								end
							end
							default: st_q <= bpl_pkg::ST_BADPOS;
						endcase
					end
				end
				// Insert: copy entries up from the tail until the slot opens, then write the value there.
				S_UP_RD: begin
					if (ptr_q == idx_q) begin
						cnt_q   <= cnt_q + CW'(1);
						state_q <= S_EMIT;
					end else begin
						state_q <= S_UP_WR;
					end
				end
				S_UP_WR: begin
					ptr_q   <= ptr_q - AW'(1);
					state_q <= S_UP_RD;
				end
				// Delete: copy entries down over the removed slot.
				S_DN_RD: begin
					if (ptr_w + 8'd1 >= cnt_w) begin
						cnt_q   <= cnt_q - CW'(1);
						state_q <= S_EMIT;
					end else begin
						state_q <= S_DN_WR;
					end
				end
				S_DN_WR: begin
					ptr_q   <= ptr_q + AW'(1);
					state_q <= S_DN_RD;
				end
				// Dump: read an entry, then hand it out when the register frees.
				S_DP_RD: state_q <= S_DP_WT;
				S_DP_WT: begin
					if (out_free) begin
						ov_q    <= 1'b1;
						ost_q   <= bpl_pkg::ST_OK;
						oent_q  <= rdata;
						olast_q <= dump_last;
						olen_q  <= 7'(cnt_q);
						ptr_q   <= ptr_q + AW'(1);
						state_q <= dump_last ? S_IDLE : S_DP_RD;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						ov_q    <= 1'b1;
						ost_q   <= st_q;
						oent_q  <= '0;
						olast_q <= 1'b1;
						olen_q  <= 7'(cnt_q);
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = ov_q;
	assign status    = ost_q;
	assign entry     = oent_q;
	assign last      = olast_q;
	assign length    = olen_q;

`include "assert_macros.svh"

	`ASSERT_SAME(a_cnt_bound, 1'b1, cnt_w <= WW'(DEPTH), "count above depth")
	`ASSERT_NEXT(a_busy_after_accept, accept, in_stall, "no stall after accepted beat")
	`ASSERT_SAME(a_ins_room, state_q == S_UP_RD || state_q == S_UP_WR,
		cnt_w < WW'(DEPTH), "insert running on a full list")

endmodule

`default_nettype wire
